// ===== rtl/ptm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptm_pkg: shared types and constants of the pixel tone mapper
// Pixel structs, curve codes, lane and divider sizes, and the 2.2 power table.
// ----------------------------------------------------------------------------
package ptm_pkg;

    localparam int FRAC      = 16;
    localparam int CODE_W    = 24;
    localparam int CW        = 34;            // curve coefficient width
    localparam int DW        = 58;            // numerator / denominator width
    localparam int QW        = 25;            // quotient bits, one extra for rounding
    localparam int DIV_STEPS = QW;
    localparam int LANE_LAT  = 34;            // registers from lane input to lane output
    localparam int POW_LOG2  = 8;
    localparam int POW_SIZE  = 1 << POW_LOG2;
    localparam int PW        = FRAC + 1;

    localparam logic [CODE_W-1:0] MAX_CODE = {CODE_W{1'b1}};
    localparam logic [CODE_W-1:0] ONE_CODE = CODE_W'(1) << FRAC;
    localparam logic [CODE_W-1:0] BLACK    = CODE_W'(((64'd1 << (FRAC + 2)) + 64'd500) / 64'd1000);

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_ACES     = 2'd1;
    localparam logic [1:0] MODE_FILMIC   = 2'd2;
    localparam logic [1:0] MODE_REINHARD = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] red_in;
        logic [CODE_W-1:0] green_in;
        logic [CODE_W-1:0] blue_in;
    } in_t;

    typedef struct packed {
        logic [CODE_W-1:0] red_out;
        logic [CODE_W-1:0] green_out;
        logic [CODE_W-1:0] blue_out;
    } out_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [CODE_W-1:0] x;
    } side_t;

    typedef struct packed {
        logic [DW-1:0] r;
        logic [QW-1:0] w;
        logic [DW-1:0] d;
        logic          sat;
        side_t         side;
    } div_stage_t;

    typedef logic [PW-1:0] pow_rom_t [0:POW_SIZE];

    function automatic logic [63:0] pow5_q32(input logic [63:0] y);
        logic [63:0] p;
        p = y;
        for (int k = 0; k < 4; k++) begin
            p = (p * y) >> 32;
        end
        return p;
    endfunction

    // entry i = (i/POW_SIZE)^2.2 as t^2 * t^(1/5), fifth root by bisection
    function automatic pow_rom_t build_pow_rom();
        pow_rom_t    rom;
        logic [63:0] t, lo, hi, mid, t2, res;
        for (int i = 0; i < POW_SIZE; i++) begin
            t  = 64'(i) << (32 - POW_LOG2);
            lo = 64'd0;
            hi = 64'hFFFF_FFFF;
            while (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (pow5_q32(mid) <= t) lo = mid;
                else hi = mid - 64'd1;
            end
            t2 = (t * t) >> 32;
            res = (t2 * lo) >> 32;
            rom[i] = PW'((res + (64'd1 << (31 - FRAC))) >> (32 - FRAC));
        end
        rom[POW_SIZE] = PW'(64'd1 << FRAC);
        return rom;
    endfunction

    localparam pow_rom_t POW_ROM = build_pow_rom();

endpackage

// ===== rtl/ptm_div.sv =====
// ----------------------------------------------------------------------------
// ptm_div: pipelined restoring divider
// Gives floor(n * 2^17 / d) one quotient bit per stage, flags n >= 256 * d.
// ----------------------------------------------------------------------------
module ptm_div import ptm_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [DW-1:0]     in_n,
    input  logic [DW-1:0]     in_d,
    input  side_t             in_side,
    output logic [QW-1:0]     q,
    output logic              sat,
    output side_t             side
);

    div_stage_t stg_reg [0:DIV_STEPS];

    // high part of n * 2^17 is n >> 8, below d unless saturated
    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0].r    <= {8'b0, in_n[DW-1:8]};
            stg_reg[0].w    <= {in_n[7:0], 17'b0};
            stg_reg[0].d    <= in_d;
            stg_reg[0].sat  <= {8'b0, in_n} >= {in_d, 8'b0};
            stg_reg[0].side <= in_side;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [DW:0]   t;
        logic          ge;
        logic [DW:0]   diff;
        div_stage_t    stg_next;

        always_comb begin
            t    = {stg_reg[j].r, stg_reg[j].w[QW-1]};
            ge   = t >= {1'b0, stg_reg[j].d};
            diff = t - {1'b0, stg_reg[j].d};
            stg_next   = stg_reg[j];
            stg_next.r = ge ? diff[DW-1:0] : t[DW-1:0];
            stg_next.w = {stg_reg[j].w[QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[j+1] <= stg_next;
            end
        end
    end

    assign q    = stg_reg[DIV_STEPS].w;
    assign sat  = stg_reg[DIV_STEPS].sat;
    assign side = stg_reg[DIV_STEPS].side;

endmodule

// ===== rtl/ptm_lane.sv =====
// ----------------------------------------------------------------------------
// ptm_lane: tone curve of one color channel
// Coefficients, products, pipelined quotient, rounding and 2.2 power lookup.
// ----------------------------------------------------------------------------
module ptm_lane import ptm_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [CODE_W-1:0] x_in,
    input  logic [1:0]        mode_in,
    output logic [CODE_W-1:0] y_out
);

    localparam int IDX_LO = FRAC - POW_LOG2;

    side_t             s1_reg;
    logic [CODE_W-1:0] z;
    logic [CODE_W-1:0] v_next;
    logic [CW-1:0]     na_next, da_next;

    side_t             s2_reg;
    logic [CODE_W-1:0] v2_reg;
    logic [CW-1:0]     na2_reg, da2_reg;

    side_t             s3_reg;
    logic [DW-1:0]     n3_reg, dp3_reg;
    logic [CW-1:0]     da3_reg;

    side_t             s4_reg;
    logic [DW-1:0]     n4_reg, d4_reg;
    logic [DW-1:0]     d_next;

    logic [QW-1:0]     dq;
    logic              dsat;
    side_t             dside;

    logic [QW:0]       rsum;
    logic [QW-1:0]     rv;
    logic [CODE_W-1:0] q_next;
    side_t             s31_reg;
    logic [CODE_W-1:0] q31_reg;

    logic [POW_LOG2-1:0] ridx;
    logic [POW_LOG2:0]   ridx1;
    logic                rover;
    side_t               s32_reg;
    logic [CODE_W-1:0]   q32_reg;
    logic [PW-1:0]       a32_reg, b32_reg;
    logic [FRAC-1:0]     f32_reg;

    logic [PW-1:0]       diff;
    side_t               s33_reg;
    logic [CODE_W-1:0]   q33_reg;
    logic [PW-1:0]       a33_reg;
    logic [PW+FRAC-1:0]  p33_reg;
    logic [PW+FRAC:0]    pround;
    logic [CODE_W-1:0]   pw;
    logic [CODE_W-1:0]   y_next;
    logic [CODE_W-1:0]   y_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg.x    <= x_in;
            s1_reg.mode <= mode_in;
        end
    end

    always_comb begin
        z = (s1_reg.x > BLACK) ? s1_reg.x - BLACK : '0;
        v_next  = s1_reg.x;
        na_next = '0;
        da_next = CW'(1);
        case (s1_reg.mode)
            MODE_ACES: begin
                na_next = CW'(s1_reg.x) * CW'(251) + (CW'(3) << FRAC);
                da_next = CW'(s1_reg.x) * CW'(243) + (CW'(59) << FRAC);
            end
            MODE_FILMIC: begin
                v_next  = z;
                na_next = CW'(z) * CW'(310) + (CW'(25) << FRAC);
                da_next = CW'(z) * CW'(310) + (CW'(85) << FRAC);
            end
            MODE_REINHARD: begin
                na_next = CW'(s1_reg.x) + (CW'(16) << FRAC);
                da_next = CW'(s1_reg.x) + (CW'(1) << FRAC);
            end
            default: begin
                na_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg  <= s1_reg;
            v2_reg  <= v_next;
            na2_reg <= na_next;
            da2_reg <= da_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg  <= s2_reg;
            n3_reg  <= DW'(v2_reg) * DW'(na2_reg);
            dp3_reg <= DW'(v2_reg) * DW'(da2_reg);
            da3_reg <= da2_reg;
        end
    end

    always_comb begin
        case (s3_reg.mode)
            MODE_ACES:     d_next = dp3_reg + (DW'(14) << (2 * FRAC));
            MODE_FILMIC:   d_next = dp3_reg + (DW'(3) << (2 * FRAC));
            MODE_REINHARD: d_next = DW'(da3_reg) << (FRAC + 4);
            default:       d_next = DW'(1);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_reg <= s3_reg;
            n4_reg <= n3_reg;
            d4_reg <= d_next;
        end
    end

    ptm_div u_div (
        .aclk    (aclk),
        .en      (en),
        .in_n    (n4_reg),
        .in_d    (d4_reg),
        .in_side (s4_reg),
        .q       (dq),
        .sat     (dsat),
        .side    (dside)
    );

    // round half up, saturate, clamp the ACES fit to one
    always_comb begin
        rsum = {1'b0, dq} + (QW+1)'(1);
        rv   = rsum[QW:1];
        if (dsat || rv[QW-1]) q_next = MAX_CODE;
        else q_next = rv[CODE_W-1:0];
        if (dside.mode == MODE_ACES && q_next > ONE_CODE) q_next = ONE_CODE;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s31_reg <= dside;
            q31_reg <= q_next;
        end
    end

    always_comb begin
        rover = q31_reg[CODE_W-1:FRAC] != '0;
        ridx  = q31_reg[FRAC-1:IDX_LO];
        ridx1 = {1'b0, ridx} + (POW_LOG2+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s32_reg <= s31_reg;
            q32_reg <= q31_reg;
            f32_reg <= {q31_reg[IDX_LO-1:0], POW_LOG2'(0)};
            if (rover) begin
                a32_reg <= POW_ROM[POW_SIZE];
                b32_reg <= POW_ROM[POW_SIZE];
            end else begin
                a32_reg <= POW_ROM[ridx];
                b32_reg <= POW_ROM[ridx1];
            end
        end
    end

    assign diff = (b32_reg > a32_reg) ? b32_reg - a32_reg : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            s33_reg <= s32_reg;
            q33_reg <= q32_reg;
            a33_reg <= a32_reg;
            p33_reg <= (PW+FRAC)'(diff) * (PW+FRAC)'(f32_reg);
        end
    end

    always_comb begin
        pround = {1'b0, p33_reg} + ((PW+FRAC+1)'(1) << (FRAC - 1));
        pw = CODE_W'(a33_reg) + CODE_W'(pround[PW+FRAC:FRAC]);
        case (s33_reg.mode)
            MODE_NONE:   y_next = s33_reg.x;
            MODE_FILMIC: y_next = pw;
            default:     y_next = q33_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y_out = y_reg;

endmodule

// ===== rtl/pixel_tone_map.sv =====
// ----------------------------------------------------------------------------
// pixel_tone_map: per-channel HDR tone mapping of one RGB pixel
// Three channel lanes run side by side; an output register merges them.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one linear RGB pixel (unsigned Q8.16 per
//   channel); m_valid/m_ready/m_data return the mapped pixel in the same
//   format. cfg_wr_en with cfg_wr_data selects the curve: none, ACES fit,
//   filmic with 2.2 power, or extended Reinhard. Change it only while idle.
//   Throughput: one pixel per clock unless the output stalls. Each lane runs
//   the 25-stage quotient pipeline plus the coefficient, product, rounding
//   and power-table stages ahead of the output register.
//   The whole pipeline advances together; while m_valid is high and
//   m_ready low, everything holds and s_ready drops, so no item is lost.
//   Reset (aresetn low, synchronous) empties the pipeline and selects the
//   pass-through curve. The power table is a constant and needs no fill.
// ----------------------------------------------------------------------------
module pixel_tone_map import ptm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data
);

    logic [1:0]          curve_mode_reg;
    logic [LANE_LAT-1:0] valid_pipe_reg;
    logic                m_valid_reg;
    out_t                m_data_reg;
    logic                advance;
    logic [CODE_W-1:0]   red_y, green_y, blue_y;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_mode_reg <= MODE_NONE;
        end else if (cfg_wr_en) begin
            curve_mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_pipe_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else if (advance) begin
            valid_pipe_reg <= {valid_pipe_reg[LANE_LAT-2:0], s_valid};
            m_valid_reg    <= valid_pipe_reg[LANE_LAT-1];
        end
    end

    ptm_lane u_red (
        .aclk (aclk), .en (advance), .x_in (s_data.red_in),
        .mode_in (curve_mode_reg), .y_out (red_y)
    );

    ptm_lane u_green (
        .aclk (aclk), .en (advance), .x_in (s_data.green_in),
        .mode_in (curve_mode_reg), .y_out (green_y)
    );

    ptm_lane u_blue (
        .aclk (aclk), .en (advance), .x_in (s_data.blue_in),
        .mode_in (curve_mode_reg), .y_out (blue_y)
    );

    // merge the lanes into the output item
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg.red_out   <= red_y;
            m_data_reg.green_out <= green_y;
            m_data_reg.blue_out  <= blue_y;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && valid_pipe_reg == '0)
        else $error("pipeline not empty after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(valid_pipe_reg) && $stable(m_data_reg))
        else $error("pipeline moved during stall");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for pixel_tone_map
// Drives pixels through every curve setting with random gaps and output stalls,
// predicts each mapped pixel in integer arithmetic and compares per channel.
// ----------------------------------------------------------------------------
module tb import ptm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 35;
    localparam int WDOG_MAX  = 20000;
    localparam int TBL_SIZE  = 256;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = MODE_NONE;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    pixel_tone_map dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    logic [1:0]  tone_curve = MODE_NONE;
    out_t        pending_pixels[$];
    logic [31:0] gamma_tbl [0:TBL_SIZE];
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          m_busy_rand = 1'b1;

    // ---------------- predictor ----------------
    function automatic logic [63:0] cube5(input logic [63:0] y);
        logic [63:0] p;
        p = y;
        for (int k = 0; k < 4; k++) p = (p * y) >> 32;
        return p;
    endfunction

    function automatic void fill_gamma_tbl();
        logic [63:0] t, lo, hi, mid, t2, res;
        for (int i = 0; i < TBL_SIZE; i++) begin
            t  = (64'(i) << 32) / TBL_SIZE;
            lo = 0;
            hi = 64'hFFFF_FFFF;
            while (lo < hi) begin
                mid = lo + ((hi - lo + 1) >> 1);
                if (cube5(mid) <= t) lo = mid;
                else hi = mid - 1;
            end
            t2  = (t * t) >> 32;
            res = (t2 * lo) >> 32;
            gamma_tbl[i] = 32'((res + (64'd1 << 15)) >> 16);
        end
        gamma_tbl[TBL_SIZE] = 32'd1 << 16;
    endfunction

    function automatic logic [63:0] ratio_q16(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q, r, f, v;
        q = n / d;
        r = n % d;
        f = 0;
        if (q > 64'hFF) return 64'hFF_FFFF;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            f = f << 1;
            if (r >= d) begin
                r = r - d;
                f = f | 1;
            end
        end
        r = r << 1;
        v = (q << 16) + f + ((r >= d) ? 1 : 0);
        return (v > 64'hFF_FFFF) ? 64'hFF_FFFF : v;
    endfunction

    function automatic logic [63:0] gamma_22(input logic [63:0] r);
        logic [63:0] pos, idx, frac, a, b, v;
        pos  = r * TBL_SIZE;
        idx  = pos >> 16;
        frac = pos & 64'hFFFF;
        if (idx >= TBL_SIZE) v = gamma_tbl[TBL_SIZE];
        else begin
            a = gamma_tbl[idx];
            b = gamma_tbl[idx + 1];
            v = a;
            if (b > a) v = v + (((b - a) * frac + 64'h8000) >> 16);
        end
        return (v > 64'hFF_FFFF) ? 64'hFF_FFFF : v;
    endfunction

    function automatic logic [23:0] tone_channel(input logic [23:0] xin);
        logic [63:0] x, n, d, v, z, one, black;
        x   = 64'(xin);
        one = 64'd1 << 16;
        case (tone_curve)
            MODE_ACES: begin
                n = x * (251 * x + 3 * one);
                d = x * (243 * x + 59 * one) + 14 * one * one;
                v = ratio_q16(n, d);
                if (v > one) v = one;
            end
            MODE_FILMIC: begin
                black = ((one << 2) + 500) / 1000;
                z = (x > black) ? x - black : 0;
                n = z * (310 * z + 25 * one);
                d = z * (310 * z + 85 * one) + 3 * one * one;
                v = gamma_22(ratio_q16(n, d));
            end
            MODE_REINHARD: begin
                n = x * (x + (one << 4));
                d = (one << 4) * (one + x);
                v = ratio_q16(n, d);
            end
            default: v = x;
        endcase
        return v[23:0];
    endfunction

    function automatic out_t tone_pixel(input in_t px);
        out_t o;
        o.red_out   = tone_channel(px.red_in);
        o.green_out = tone_channel(px.green_in);
        o.blue_out  = tone_channel(px.blue_in);
        return o;
    endfunction

    // ---------------- result side ----------------
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel %h", m_data);
                n_errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_data.red_out !== want.red_out) begin
                    $error("red_out exp %h got %h", want.red_out, m_data.red_out);
                    n_errors++;
                end
                if (m_data.green_out !== want.green_out) begin
                    $error("green_out exp %h got %h", want.green_out, m_data.green_out);
                    n_errors++;
                end
                if (m_data.blue_out !== want.blue_out) begin
                    $error("blue_out exp %h got %h", want.blue_out, m_data.blue_out);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    // random stall pattern, with a long hold-off on request
    always @(posedge aclk) begin
        int r;
        if (hold_off || !aresetn) m_ready <= 1'b0;
        else if (!m_busy_rand) m_ready <= 1'b1;
        else begin
            r = $urandom_range(0, 99);
            m_ready <= (r < 70) ? 1'b1 : (r < 97) ? 1'b0 : 1'b0;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("timeout");
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic logic [23:0] rand_code();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(0, 255));
            1: return 24'($urandom_range(0, 24'h1_FFFF));
            2: return 24'($urandom_range(0, 24'h8_0000));
            3: return 24'hFF_FFFF - 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    // valid stays high between back-to-back items; drop it only for a gap
    task automatic send_pixel(input in_t px, input bit gaps);
        int g;
        g = 0;
        if (gaps) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        end
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        pending_pixels = {pending_pixels, tone_pixel(px)};
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    task automatic send_rgb(input logic [23:0] r, g, b);
        in_t px;
        px.red_in = r;
        px.green_in = g;
        px.blue_in = b;
        send_pixel(px, 1'b1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic set_curve(input logic [1:0] mode);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tone_curve = mode;
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        logic [1:0] modes [4] = '{MODE_NONE, MODE_ACES, MODE_FILMIC, MODE_REINHARD};
        foreach (modes[i]) begin
            set_curve(modes[i]);
            send_rgb(24'h00_0000, 24'hFF_FFFF, 24'h01_0000);
            send_rgb(24'h00_0106, 24'h00_0105, 24'h00_0107);  // around the black offset
            send_rgb(24'h04_0000, 24'h00_0001, 24'hAA_5555);
            send_rgb(24'h55_AAAA, 24'h10_0000, 24'h00_8000);
        end
    endtask

    task automatic test_random(input int count);
        in_t px;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) set_curve(2'($urandom_range(0, 3)));
            m_busy_rand = (i % 150) >= 40;
            px.red_in = rand_code();
            px.green_in = rand_code();
            px.blue_in = rand_code();
            send_pixel(px, (i % 100) >= 20);
        end
    endtask

    task automatic test_backpressure();
        in_t px;
        set_curve(MODE_REINHARD);
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 60; i++) begin
                px = {24'($urandom), 24'($urandom), 24'($urandom)};
                send_pixel(px, 1'b0);
            end
        join
        drain();
        set_curve(MODE_ACES);
    endtask

    initial begin
        fill_gamma_tbl();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(470);
        set_curve(MODE_NONE);
        drain();
        $display("sent %0d pixels over all four curves, checked %0d results", n_sent, n_checked);
        if (n_errors == 0 && pending_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== pixel_tone_map.f =====
rtl/ptm_pkg.sv
rtl/ptm_div.sv
rtl/ptm_lane.sv
rtl/pixel_tone_map.sv
tb/tb.sv
